[rtl/rds_pkg.sv]
`default_nettype none

package rds_pkg;

  localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] POS_INF   = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] POS_ZERO  = 64'h0000_0000_0000_0000;

  localparam int unsigned QueueDepth = 2;

  // One queued word: the contribution with the bounds in force when it was taken.
  typedef struct packed {
    logic [63:0] x;
    logic        last;
    logic        zero_bound;
    logic [63:0] m1;
    logic [63:0] m2;
  } item_t;

  // Smallest power of two not below q, for a non-negative binary64 pattern.
  function automatic logic [63:0] pow2_ceil(input logic [63:0] q);
    logic [10:0] e;
    logic [51:0] m;
    logic [51:0] s;
    logic [63:0] r;
    e = q[62:52];
    m = q[51:0];
    s = m - 52'd1;
    s = s | (s >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    s = s | (s >> 16);
    s = s | (s >> 32);
    if (e == 11'h7FF) begin
      r = q;
    end else if (e == 11'd0) begin
      r = (m == 52'd0) ? POS_ZERO : ({12'd0, s} + 64'd1);
    end else if (m == 52'd0) begin
      r = q;
    end else if (e >= 11'h7FE) begin
      r = POS_INF;
    end else begin
      r = {1'b0, e + 11'd1, 52'd0};
    end
    return r;
  endfunction

  function automatic logic [63:0] canon(input logic [63:0] v);
    return ((v[62:52] == 11'h7FF) && (v[51:0] != 52'd0)) ? CANON_NAN : v;
  endfunction

endpackage

`default_nettype wire

[rtl/rds_fpadd.sv]
`default_nettype none

module rds_fpadd (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             out_valid_o,
  output logic [63:0]      y_o
);
  import rds_pkg::*;

  typedef struct packed {
    logic        spec;
    logic [63:0] sval;
    logic        sub;
    logic        sgn;
    logic        sz;
    logic [11:0] e;
  } ctl_t;

  // stage 1: unpack, order by magnitude, align
  logic        sa, sb, nan_a, nan_b, inf_a, inf_b, a_big;
  logic [63:0] big, sml;
  logic [10:0] ebe, ese, dif;
  logic [5:0]  dcl;
  logic [52:0] mbg, msm;
  logic [111:0] wide;
  logic [55:0] al;

  always_comb begin
    sa    = a_i[63];
    sb    = b_i[63];
    nan_a = (&a_i[62:52]) & (|a_i[51:0]);
    nan_b = (&b_i[62:52]) & (|b_i[51:0]);
    inf_a = (&a_i[62:52]) & ~(|a_i[51:0]);
    inf_b = (&b_i[62:52]) & ~(|b_i[51:0]);
    a_big = a_i[62:0] >= b_i[62:0];
    big   = a_big ? a_i : b_i;
    sml   = a_big ? b_i : a_i;
    ebe   = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    ese   = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
    mbg   = {|big[62:52], big[51:0]};
    msm   = {|sml[62:52], sml[51:0]};
    dif   = ebe - ese;
    dcl   = (dif > 11'd63) ? 6'd63 : dif[5:0];
    wide  = {msm, 3'b000, 56'd0} >> dcl;
    al    = {wide[111:57], wide[56] | (|wide[55:0])};
  end

  logic        v1_q, v2_q, v3_q, v4_q;
  ctl_t        c1_q, c2_q, c3_q;
  ctl_t        c1_d;
  logic [55:0] ma1_q, mb1_q;
  logic [56:0] sum2_q, sum3_q;
  logic [5:0]  lz3_q;
  logic [63:0] y4_q;

  always_comb begin
    c1_d.spec = nan_a | nan_b | inf_a | inf_b;
    c1_d.sval = (nan_a | nan_b | (inf_a & inf_b & (sa != sb))) ? CANON_NAN :
                (inf_a ? a_i : b_i);
    c1_d.sub  = sa ^ sb;
    c1_d.sgn  = big[63];
    c1_d.sz   = sa & sb;
    c1_d.e    = {1'b0, ebe};
  end

  // stage 3: leading zero count
  logic [5:0] lz;
  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 56; i++) begin
      if (sum2_q[i]) begin
        lz = 6'(55 - i);
      end
    end
  end

  // stage 4: normalize, round to nearest even, pack
  logic [55:0] nm;
  logic [11:0] e2, em1;
  logic [5:0]  sh;
  logic [10:0] ef;
  logic        inc;
  logic [62:0] pk;
  logic [63:0] y_d;

  always_comb begin
    em1 = c3_q.e - 12'd1;
    sh  = ({6'd0, lz3_q} < em1) ? lz3_q : em1[5:0];
    if (sum3_q[56]) begin
      nm = {sum3_q[56:2], sum3_q[1] | sum3_q[0]};
      e2 = c3_q.e + 12'd1;
    end else begin
      nm = sum3_q[55:0] << sh;
      e2 = c3_q.e - {6'd0, sh};
    end
    ef  = nm[55] ? e2[10:0] : 11'd0;
    inc = nm[2] & (nm[1] | nm[0] | nm[3]);
    pk  = {ef, nm[54:3]} + {62'd0, inc};
    if (c3_q.spec) begin
      y_d = c3_q.sval;
    end else if (sum3_q == 57'd0) begin
      y_d = {c3_q.sz, 63'd0};
    end else if (e2 >= 12'd2047) begin
      y_d = {c3_q.sgn, POS_INF[62:0]};
    end else begin
      y_d = {c3_q.sgn, pk};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q   <= c1_d;
    ma1_q  <= {mbg, 3'b000};
    mb1_q  <= al;
    c2_q   <= c1_q;
    sum2_q <= c1_q.sub ? ({1'b0, ma1_q} - {1'b0, mb1_q}) : ({1'b0, ma1_q} + {1'b0, mb1_q});
    c3_q   <= c2_q;
    sum3_q <= sum2_q;
    lz3_q  <= lz;
    y4_q   <= y_d;
  end

  assign out_valid_o = v4_q;
  assign y_o         = y4_q;

endmodule

`default_nettype wire

[rtl/rds_bound.sv]
`default_nettype none

module rds_bound (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  output logic             busy_o,
  output logic [63:0]      m1_o,
  output logic [63:0]      m2_o
);
  import rds_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_NORM  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_ROUND = 3'd4;

  localparam logic [2:0] PH_MUL1 = 3'd0;
  localparam logic [2:0] PH_DIV1 = 3'd1;
  localparam logic [2:0] PH_SCL  = 3'd2;
  localparam logic [2:0] PH_MUL2 = 3'd3;
  localparam logic [2:0] PH_DIV2 = 3'd4;

  localparam logic [6:0] DivLast = 7'd108;

  logic [10:0]        num_q, num_d;
  logic [63:0]        mx_q, mx_d;
  logic [2:0]         st_q, st_d, ph_q, ph_d;
  logic [63:0]        val_q, val_d, m1_q, m1_d, m2_q, m2_d;
  logic [63:0]        sig_q, sig_d;
  logic signed [12:0] ex_q, ex_d;
  logic               stk_q, stk_d, dvd_q, dvd_d;
  logic [6:0]         cnt_q, cnt_d;
  logic [51:0]        rem_q, rem_d;
  logic [63:0]        quo_q, quo_d;

  // operand unpack
  logic [10:0] ve;
  logic [52:0] mv;
  logic        vnan, vinf, vzero, is_div;
  logic [63:0] spec_v, prod;
  logic        spec;
  logic signed [12:0] ee;

  always_comb begin
    ve     = val_q[62:52];
    mv     = {|ve, val_q[51:0]};
    vnan   = (&ve) & (|val_q[51:0]);
    vinf   = (&ve) & ~(|val_q[51:0]);
    vzero  = (val_q[62:0] == 63'd0);
    ee     = $signed({2'b00, ((ve == 11'd0) ? 11'd1 : ve)});
    is_div = (ph_q == PH_DIV1) || (ph_q == PH_DIV2);
    prod   = num_q * mv;
    spec   = vnan | vinf | vzero;
    spec_v = vnan ? CANON_NAN : (vinf ? POS_INF : POS_ZERO);
    if ((ph_q == PH_MUL1) || (ph_q == PH_MUL2)) begin
      spec = spec | (num_q == 11'd0);
      if (vinf && (num_q == 11'd0)) begin
        spec_v = CANON_NAN;
      end else if (!vnan && !vinf) begin
        spec_v = POS_ZERO;
      end
    end
  end

  // rounding to binary64
  logic               rnrm, rovf, runf, rb, rst, rinc;
  logic signed [12:0] dtmp;
  logic [6:0]         dsc;
  logic [63:0]        kept, lmask, rbits, rres;
  logic [10:0]        efld;
  logic [62:0]        pk;

  always_comb begin
    rnrm  = ex_q >= -13'sd1085;
    rovf  = ex_q > 13'sd960;
    dtmp  = -13'sd1074 - ex_q;
    runf  = !rnrm && (dtmp > 13'sd64);
    dsc   = rnrm ? 7'd11 : dtmp[6:0];
    kept  = sig_q >> dsc;
    rb    = sig_q[6'(dsc - 7'd1)];
    lmask = (64'd1 << 6'(dsc - 7'd1)) - 64'd1;
    rst   = (|(sig_q & lmask)) | stk_q;
    rinc  = rb & (rst | kept[0]);
    efld  = rnrm ? 11'(ex_q + 13'sd1086) : 11'd0;
    pk    = {efld, kept[51:0]} + {62'd0, rinc};
    rbits = rovf ? POS_INF : (runf ? POS_ZERO : {1'b0, pk});
  end

  // long division by 2^51 - n
  logic [52:0] dvs, r2;
  logic        nbit, ge;
  always_comb begin
    dvs  = 53'(64'd1 << 51) - {42'd0, num_q};
    nbit = (cnt_q < 7'd53) ? sig_q[6'(7'd63 - cnt_q)] : 1'b0;
    r2   = {rem_q, nbit};
    ge   = r2 >= dvs;
  end

  always_comb begin
    num_d = num_q;
    mx_d  = mx_q;
    st_d  = st_q;
    ph_d  = ph_q;
    val_d = val_q;
    m1_d  = m1_q;
    m2_d  = m2_q;
    sig_d = sig_q;
    ex_d  = ex_q;
    stk_d = stk_q;
    dvd_d = dvd_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    rres  = rbits;

    unique case (st_q)
      ST_IDLE: begin
      end
      ST_LOAD: begin
        stk_d = 1'b0;
        dvd_d = 1'b0;
        if (spec) begin
          rres = spec_v;
          st_d = ST_ROUND;
        end else begin
          st_d = ST_NORM;
          unique case (ph_q)
            PH_MUL1, PH_MUL2: begin
              sig_d = prod;
              ex_d  = ee - 13'sd1075;
            end
            PH_SCL: begin
              sig_d = {mv, 11'd0};
              ex_d  = ee - 13'sd1137;
            end
            default: begin
              sig_d = {mv, 11'd0};
              ex_d  = ee - 13'sd1086;
            end
          endcase
        end
      end
      ST_NORM: begin
        if (sig_q[63]) begin
          if (is_div && !dvd_q) begin
            st_d  = ST_DIV;
            cnt_d = 7'd0;
            rem_d = 52'd0;
            quo_d = 64'd0;
          end else begin
            st_d = ST_ROUND;
          end
        end else begin
          sig_d = {sig_q[62:0], 1'b0};
          ex_d  = ex_q - 13'sd1;
        end
      end
      ST_DIV: begin
        rem_d = ge ? 52'(r2 - dvs) : r2[51:0];
        quo_d = {quo_q[62:0], ge};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == DivLast) begin
          sig_d = {quo_q[62:0], ge};
          stk_d = (rem_d != 52'd0);
          ex_d  = ex_q + 13'sd6;
          dvd_d = 1'b1;
          st_d  = ST_NORM;
        end
      end
      ST_ROUND: begin
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    // phase end: a special operand skips straight here from the load
    if ((st_q == ST_ROUND) || ((st_q == ST_LOAD) && spec)) begin
      if (is_div) begin
        rres = pow2_ceil(rres);
      end
      val_d = rres;
      st_d  = ST_LOAD;
      unique case (ph_q)
        PH_DIV1: begin
          m1_d = rres;
          ph_d = PH_SCL;
        end
        PH_DIV2: begin
          m2_d = rres;
          st_d = ST_IDLE;
        end
        default: begin
          ph_d = ph_q + 3'd1;
        end
      endcase
    end

    if (cfg_we_i) begin
      st_d = ST_LOAD;
      ph_d = PH_MUL1;
      if (cfg_index_i) begin
        mx_d  = cfg_data_i;
        val_d = {1'b0, cfg_data_i[62:0]};
      end else begin
        num_d = cfg_data_i[10:0];
        val_d = {1'b0, mx_q[62:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= 11'd1;
      mx_q  <= 64'd0;
      st_q  <= ST_IDLE;
      ph_q  <= PH_MUL1;
      m1_q  <= POS_ZERO;
      m2_q  <= POS_ZERO;
    end else begin
      num_q <= num_d;
      mx_q  <= mx_d;
      st_q  <= st_d;
      ph_q  <= ph_d;
      m1_q  <= m1_d;
      m2_q  <= m2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    sig_q <= sig_d;
    ex_q  <= ex_d;
    stk_q <= stk_d;
    dvd_q <= dvd_d;
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o = (st_q != ST_IDLE);
  assign m1_o   = m1_q;
  assign m2_o   = m2_q;

endmodule

`default_nettype wire

[rtl/rds_front.sv]
`default_nettype none

module rds_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic [63:0]    contribution_i,
  input  wire logic           last_item_i,
  input  wire logic           bound_busy_i,
  input  wire logic [63:0]    m1_i,
  input  wire logic [63:0]    m2_i,
  output logic                head_valid_o,
  output rds_pkg::item_t      head_o,
  input  wire logic           pop_i
);
  import rds_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;
  item_t           it;

  assign in_stall_o   = (cnt_q == (PtrW+1)'(QueueDepth)) | bound_busy_i;
  assign push         = in_valid_i & ~in_stall_o;
  assign head_valid_o = (cnt_q != '0);
  assign pop          = pop_i & head_valid_o;
  assign head_o       = mem_q[rd_q];

  always_comb begin
    it.x          = contribution_i;
    it.last       = last_item_i;
    it.zero_bound = (m1_i == POS_ZERO);
    it.m1         = m1_i;
    it.m2         = m2_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= it;
    end
  end

endmodule

`default_nettype wire

[rtl/rds_back.sv]
`default_nettype none

module rds_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           head_valid_i,
  input  rds_pkg::item_t      head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [63:0]         result_sum_o
);
  import rds_pkg::*;

  localparam logic [2:0] OP_T   = 3'd0;
  localparam logic [2:0] OP_HI  = 3'd1;
  localparam logic [2:0] OP_XL  = 3'd2;
  localparam logic [2:0] OP_T2  = 3'd3;
  localparam logic [2:0] OP_LO  = 3'd4;
  localparam logic [2:0] OP_HA  = 3'd5;
  localparam logic [2:0] OP_LA  = 3'd6;
  localparam logic [2:0] OP_SUM = 3'd7;

  logic        act_q, wait_q, ov_q;
  logic [2:0]  op_q;
  logic [63:0] x_q, m1_q, m2_q, t_q, hi_q, lo_q, hacc_q, lacc_q, out_q;
  logic        last_q;

  logic        issue, add_v;
  logic [63:0] opa, opb, add_y;

  function automatic logic [63:0] neg(input logic [63:0] v);
    return {~v[63], v[62:0]};
  endfunction

  always_comb begin
    unique case (op_q)
      OP_T: begin
        opa = m1_q;
        opb = x_q;
      end
      OP_HI: begin
        opa = t_q;
        opb = neg(m1_q);
      end
      OP_XL: begin
        opa = x_q;
        opb = neg(hi_q);
      end
      OP_T2: begin
        opa = m2_q;
        opb = t_q;
      end
      OP_LO: begin
        opa = t_q;
        opb = neg(m2_q);
      end
      OP_HA: begin
        opa = hacc_q;
        opb = hi_q;
      end
      OP_LA: begin
        opa = lacc_q;
        opb = lo_q;
      end
      default: begin
        opa = hacc_q;
        opb = lacc_q;
      end
    endcase
  end

  assign issue = act_q & ~wait_q & ((op_q != OP_SUM) | ~ov_q);
  assign pop_o = ~act_q & head_valid_i;

  rds_fpadd u_add (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (issue),
    .a_i        (opa),
    .b_i        (opb),
    .out_valid_o(add_v),
    .y_o        (add_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      wait_q <= 1'b0;
      ov_q   <= 1'b0;
      op_q   <= OP_T;
      hacc_q <= POS_ZERO;
      lacc_q <= POS_ZERO;
    end else begin
      if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
      if (pop_o) begin
        act_q <= 1'b1;
        op_q  <= head_i.zero_bound ? OP_HA : OP_T;
      end
      if (issue) begin
        wait_q <= 1'b1;
      end
      if (add_v) begin
        wait_q <= 1'b0;
        unique case (op_q)
          OP_HA: hacc_q <= add_y;
          OP_LA: lacc_q <= add_y;
          OP_SUM: begin
            hacc_q <= POS_ZERO;
            lacc_q <= POS_ZERO;
            ov_q   <= 1'b1;
          end
          default: begin
          end
        endcase
        if ((op_q == OP_SUM) || ((op_q == OP_LA) && !last_q)) begin
          act_q <= 1'b0;
        end else begin
          op_q <= op_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      x_q    <= head_i.x;
      last_q <= head_i.last;
      m1_q   <= head_i.m1;
      m2_q   <= head_i.m2;
      hi_q   <= POS_ZERO;
      lo_q   <= POS_ZERO;
    end
    if (add_v) begin
      unique case (op_q)
        OP_T, OP_XL, OP_T2: t_q <= add_y;
        OP_HI: hi_q <= add_y;
        OP_LO: lo_q <= add_y;
        OP_SUM: out_q <= canon(add_y);
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o  = ov_q;
  assign result_sum_o = out_q;

endmodule

`default_nettype wire

[rtl/reproducible_double_sum.sv]
`default_nettype none

// Order-independent sum of binary64 words by two-level pre-rounding. Each
// contribution is split against the bounds M1 and M2 into a high and a low
// part that go into two accumulators; the word marked last returns their sum
// (NaN results as the canonical quiet NaN) and clears both. Words enter a
// two-deep queue and are worked off by one four-stage adder; each dependent
// add issues only once the previous one has left its pipeline, and a word is
// picked up from the queue only once the previous word is done. A
// contribution takes seven dependent adds, one more when marked last, and
// just the two accumulating adds (three when last) when the bound M1 is zero.
// A last word also waits while the previous sum is still held on a stalled
// output. After any configuration write the bounds are rebuilt by a sequencer
// of multiplies and bit-serial divisions; input words are stalled meanwhile.
module reproducible_double_sum (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] contribution_i,
  input  wire logic        last_item_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      result_sum_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);
  import rds_pkg::*;

  logic        busy, head_valid, pop;
  logic [63:0] m1, m2;
  item_t       head;

  rds_bound u_bound (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .busy_o     (busy),
    .m1_o       (m1),
    .m2_o       (m2)
  );

  rds_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .contribution_i(contribution_i),
    .last_item_i   (last_item_i),
    .bound_busy_i  (busy),
    .m1_i          (m1),
    .m2_i          (m2),
    .head_valid_o  (head_valid),
    .head_o        (head),
    .pop_i         (pop)
  );

  rds_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_sum_o (result_sum_o)
  );

endmodule

`default_nettype wire

[rtl/rds_chk.sv]
`default_nettype none

module rds_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] result_sum_o,
  input wire logic        cfg_we_i
);
  import rds_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(result_sum_o))
    else $error("result word changed while stalled");

  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("input taken before bounds rebuilt");

  a_nan_canon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_sum_o[62:52] == 11'h7FF) && (result_sum_o[51:0] != 52'd0)
    |-> result_sum_o == CANON_NAN)
    else $error("non-canonical NaN result");

endmodule

bind reproducible_double_sum rds_chk u_rds_chk (.*);

`default_nettype wire
